@@ sv/rmtp_pkg.sv @@
// Package for the momentum rotation block: CORDIC arctangent table, widths
// and the struct that travels down the cell chain. No dependencies.
package rmtp_pkg;

  localparam int CoefBits   = 30;
  localparam int AtanCount  = 24;
  localparam int PhaseW     = 34;   // CORDIC working width
  localparam int CompW      = 32;
  localparam int CoefW      = 32;   // clamped coefficients, range +-2^30
  localparam int ProdW      = 64;

  localparam logic signed [PhaseW-1:0] CordicGain = 34'sh026DD3B6A;

  function automatic logic signed [PhaseW-1:0] atan_phase(input logic [4:0] idx);
    logic signed [PhaseW-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 34'sh020000000;
      5'd1:  v = 34'sh012E4051E;
      5'd2:  v = 34'sh009FB385B;
      5'd3:  v = 34'sh0051111D4;
      5'd4:  v = 34'sh0028B0D43;
      5'd5:  v = 34'sh00145D7E1;
      5'd6:  v = 34'sh000A2F61E;
      5'd7:  v = 34'sh000517C55;
      5'd8:  v = 34'sh00028BE53;
      5'd9:  v = 34'sh000145F2F;
      5'd10: v = 34'sh0000A2F98;
      5'd11: v = 34'sh0000517CC;
      5'd12: v = 34'sh000028BE6;
      5'd13: v = 34'sh0000145F3;
      5'd14: v = 34'sh00000A2FA;
      5'd15: v = 34'sh00000517D;
      5'd16: v = 34'sh0000028BE;
      5'd17: v = 34'sh00000145F;
      5'd18: v = 34'sh000000A30;
      5'd19: v = 34'sh000000518;
      5'd20: v = 34'sh00000028C;
      5'd21: v = 34'sh000000146;
      5'd22: v = 34'sh0000000A3;
      5'd23: v = 34'sh000000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One rotator's working state for one angle.
  typedef struct packed {
    logic signed [PhaseW-1:0] x;
    logic signed [PhaseW-1:0] y;
    logic signed [PhaseW-1:0] z;
    logic [1:0]               quad;
  } rot_t;

  // What one cell hands to the next: both rotators plus the vector.
  typedef struct packed {
    logic                    vld;
    rot_t                    th;
    rot_t                    ph;
    logic signed [CompW-1:0] px;
    logic signed [CompW-1:0] py;
    logic signed [CompW-1:0] pz;
  } cell_t;

endpackage

@@ sv/rmtp_cell.sv @@
// One CORDIC micro-rotation cell for both angles; hands its state on each cycle
// in which en is high. Depends on rmtp_pkg.
module rmtp_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  rmtp_pkg::cell_t d_in,
  output rmtp_pkg::cell_t d_out
);

  rmtp_pkg::cell_t cell_r, cell_nxt;

  function automatic rmtp_pkg::rot_t micro(input rmtp_pkg::rot_t a);
    rmtp_pkg::rot_t o;
    logic signed [rmtp_pkg::PhaseW-1:0] at;
    at = rmtp_pkg::atan_phase(5'(STEP));
    o = a;
    if (!a.z[rmtp_pkg::PhaseW-1]) begin
      o.x = a.x - (a.y >>> STEP);
      o.y = a.y + (a.x >>> STEP);
      o.z = a.z - at;
    end else begin
      o.x = a.x + (a.y >>> STEP);
      o.y = a.y - (a.x >>> STEP);
      o.z = a.z + at;
    end
    return o;
  endfunction

  always_comb begin
    cell_nxt    = d_in;
    cell_nxt.th = micro(d_in.th);
    cell_nxt.ph = micro(d_in.ph);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (en) begin
      cell_r.th <= cell_nxt.th;
      cell_r.ph <= cell_nxt.ph;
      cell_r.px <= cell_nxt.px;
      cell_r.py <= cell_nxt.py;
      cell_r.pz <= cell_nxt.pz;
    end
  end

  assign d_out = cell_r;

endmodule

@@ sv/rmtp_matrix.sv @@
// Quadrant fix-up, matrix build and matrix-vector product, four register stages.
// Depends on rmtp_pkg.
module rmtp_matrix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  rmtp_pkg::cell_t              d_in,
  output logic                         vld,
  output logic signed [31:0]           px,
  output logic signed [31:0]           py,
  output logic signed [31:0]           pz,
  output logic                         ovf
);

  localparam int W  = rmtp_pkg::CoefW;
  localparam int PW = rmtp_pkg::ProdW;
  localparam logic signed [W-1:0] One = W'(64'sd1 <<< rmtp_pkg::CoefBits);
  localparam logic signed [PW-1:0] Half = PW'(64'sd1 <<< (rmtp_pkg::CoefBits - 1));

  function automatic logic signed [W-1:0] clampc(input logic signed [rmtp_pkg::PhaseW-1:0] v);
    logic signed [rmtp_pkg::PhaseW-1:0] o;
    o = rmtp_pkg::PhaseW'(One);
    if (v > o) return One;
    if (v < -o) return -One;
    return W'(v);
  endfunction

  function automatic void quad_map(input rmtp_pkg::rot_t r,
                                   output logic signed [W-1:0] c,
                                   output logic signed [W-1:0] s);
    case (r.quad)
      2'd0:    begin c = clampc(r.x);  s = clampc(r.y);  end
      2'd1:    begin c = clampc(-r.y); s = clampc(r.x);  end
      2'd2:    begin c = clampc(-r.x); s = clampc(-r.y); end
      default: begin c = clampc(r.y);  s = clampc(-r.x); end
    endcase
  endfunction

  function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + Half) >>> rmtp_pkg::CoefBits;
    return W'(t);
  endfunction

  // stage 1: coefficients
  logic signed [W-1:0] ct_r, st_r, cp_r, sp_r;
  logic signed [31:0]  a0_r, a1_r, a2_r, b0_r, b1_r, b2_r, c0_r, c1_r, c2_r;
  logic                v1_r, v2_r, v3_r, v4_r;
  logic signed [W-1:0] ct_nxt, st_nxt, cp_nxt, sp_nxt;

  always_comb begin
    quad_map(d_in.th, ct_nxt, st_nxt);
    quad_map(d_in.ph, cp_nxt, sp_nxt);
  end

  // stage 2: products of coefficients
  logic signed [W-1:0] m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m21_r, m22_r;

  // stage 3: eight products; stage 4: sums, rounding and saturation
  logic signed [PW-1:0] q00_r, q01_r, q02_r, q10_r, q11_r, q12_r, q21_r, q22_r;

  function automatic logic signed [31:0] sat(input logic signed [PW-1:0] s,
                                             output logic o);
    logic signed [PW-1:0] v;
    v = (s + Half) >>> rmtp_pkg::CoefBits;
    o = 1'b0;
    if (v > 64'sd2147483647) begin o = 1'b1; return 32'sh7FFFFFFF; end
    if (v < -64'sd2147483648) begin o = 1'b1; return 32'sh80000000; end
    return 32'(v);
  endfunction

  logic signed [31:0] x_nxt, y_nxt, z_nxt;
  logic ox, oy, oz;
  always_comb begin
    x_nxt = sat(q00_r + q01_r + q02_r, ox);
    y_nxt = sat(q10_r + q11_r + q12_r, oy);
    z_nxt = sat(q21_r + q22_r, oz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= d_in.vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
    if (en) begin
      ct_r <= ct_nxt; st_r <= st_nxt; cp_r <= cp_nxt; sp_r <= sp_nxt;
      a0_r <= d_in.px; a1_r <= d_in.py; a2_r <= d_in.pz;
      m00_r <= -sp_r;
      m01_r <= -rnd(PW'(ct_r) * PW'(cp_r));
      m02_r <= rnd(PW'(st_r) * PW'(cp_r));
      m10_r <= cp_r;
      m11_r <= -rnd(PW'(ct_r) * PW'(sp_r));
      m12_r <= rnd(PW'(st_r) * PW'(sp_r));
      m21_r <= st_r;
      m22_r <= ct_r;
      b0_r <= a0_r; b1_r <= a1_r; b2_r <= a2_r;
      q00_r <= PW'(m00_r) * PW'(b0_r);
      q01_r <= PW'(m01_r) * PW'(b1_r);
      q02_r <= PW'(m02_r) * PW'(b2_r);
      q10_r <= PW'(m10_r) * PW'(b0_r);
      q11_r <= PW'(m11_r) * PW'(b1_r);
      q12_r <= PW'(m12_r) * PW'(b2_r);
      q21_r <= PW'(m21_r) * PW'(b1_r);
      q22_r <= PW'(m22_r) * PW'(b2_r);
      c0_r <= x_nxt; c1_r <= y_nxt; c2_r <= z_nxt;
    end
  end

  logic ovf_r;
  always_ff @(posedge clk) begin
    if (en) ovf_r <= ox | oy | oz;
  end

  assign vld = v4_r;
  assign px  = c0_r;
  assign py  = c1_r;
  assign pz  = c2_r;
  assign ovf = ovf_r;

endmodule

@@ sv/rotate_momentum_theta_phi.sv @@
// Rotates a three-momentum by theta and phi through a chain of CORDIC cells
// and a matrix stage.
// Throughput: one transaction per cycle; the whole chain advances when the
// output register is empty or being taken.
// Reset (rst_n low, synchronous) clears all valid flags; other state is not reset.
// Depends on rmtp_pkg, rmtp_cell and rmtp_matrix.
module rotate_momentum_theta_phi #(
  parameter int FRACTION_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // theta_angle[15:0], phi_angle[31:16], px_in[63:32], py_in[95:64], pz_in[127:96]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // px_out[31:0], py_out[63:32], pz_out[95:64]
  output logic [95:0]  out_tdata,
  // overflow_flag
  output logic         out_tuser
);

  localparam int Stages = (CORDIC_STAGES < rmtp_pkg::AtanCount) ?
                          CORDIC_STAGES : rmtp_pkg::AtanCount;
  localparam int PW = rmtp_pkg::PhaseW;

  // FRACTION_BITS sets only the meaning of the component format.

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  function automatic rmtp_pkg::rot_t seed(input logic [15:0] ang);
    rmtp_pkg::rot_t r;
    logic [31:0] ph, ru;
    ph = {ang, 16'd0};
    r.quad = 2'((ph + 32'h2000_0000) >> 30);
    ru = ph - {r.quad, 30'd0};
    r.x = rmtp_pkg::CordicGain;
    r.y = '0;
    r.z = PW'($signed(ru));
    return r;
  endfunction

  rmtp_pkg::cell_t chain [0:Stages];

  always_comb begin
    chain[0].vld = in_tvalid;
    chain[0].th  = seed(in_tdata[15:0]);
    chain[0].ph  = seed(in_tdata[31:16]);
    chain[0].px  = $signed(in_tdata[63:32]);
    chain[0].py  = $signed(in_tdata[95:64]);
    chain[0].pz  = $signed(in_tdata[127:96]);
  end

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    rmtp_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_in(chain[g]), .d_out(chain[g+1])
    );
  end

  logic               vld;
  logic signed [31:0] px, py, pz;
  logic               ovf;

  rmtp_matrix u_mat (
    .clk(clk), .rst_n(rst_n), .en(en), .d_in(chain[Stages]),
    .vld(vld), .px(px), .py(py), .pz(pz), .ovf(ovf)
  );

  assign out_tvalid = vld;
  assign out_tdata  = {pz, py, px};
  assign out_tuser  = ovf;

endmodule

@@ sv/rmtp_checker.sv @@
// Port-level checks for rotate_momentum_theta_phi, bound to the top level.
// Depends only on the top level's ports.
module rmtp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [95:0]  out_tdata,
  input logic         out_tuser
);

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Input is taken whenever the output side is free.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input refused while output free");

  // A stall upstream follows only from a stall downstream.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

  // No result straight after reset is released.
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result straight after reset");

endmodule

bind rotate_momentum_theta_phi rmtp_checker u_rmtp_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
